[rtl/fbpa_pkg.sv]
// Shared types, widths and codes of the fixed block pool allocator.
package fbpa_pkg;

   localparam int ACTION_W   = 2;
   localparam int OFFSET_W   = 22;
   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 13;
   localparam int COUNT_W    = 11;
   localparam int STEP_W     = $clog2(OFFSET_W);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_MAX_BLOCKS      = 1024;
   localparam int DEF_MAX_BLOCK_BYTES = 4096;

   localparam logic [BYTES_W-1:0] LINK_BYTES      = BYTES_W'(8);
   localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = BYTES_W'(64);
   localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = COUNT_W'(1024);

   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REBUILD = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STS_ALIGN = 2'd3;

   localparam logic CSR_SEL_BYTES = 1'b0;
   localparam logic CSR_SEL_COUNT = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [OFFSET_W-1:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] alloc_offset;
   } rsp_word_type;

endpackage

[rtl/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator with a LIFO free list held in a link RAM.
// One word is in work at a time; req_stall is high from acceptance until the result is
// handed to the output register. The work runs on one shared 22-bit add/subtract unit:
// an allocate takes 13 shift-add steps for index times block size, a free takes 22
// restoring-division steps for quotient and remainder, then the range/alignment check
// and link write, and a rebuild does one link RAM write per block, with the count capped
// at the smaller of MAX_BLOCKS and 2047. An allocate on an empty list, a rebuild with a
// zero count or an unused action goes straight to the response state. The output
// register lets the next word be accepted while a result waits on rsp_stall.
// The link RAM has no reset; only a rebuild or a free makes its entries meaningful.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
   parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW     = $clog2(MAX_BLOCKS);
   localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CW     = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam int SZ_CAP = (MAX_BLOCK_BYTES > 2**BYTES_W - 1) ? 2**BYTES_W - 1
                                                              : MAX_BLOCK_BYTES;
   localparam int CNT_CAP = (MAX_BLOCKS > 2**COUNT_W - 1) ? 2**COUNT_W - 1 : MAX_BLOCKS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_CHK   = 6'b001000,
      ST_SWEEP = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [BYTES_W-1:0]    block_bytes_ff, block_bytes_in;
   logic [COUNT_W-1:0]    block_count_ff, block_count_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic [OFFSET_W-1:0]   acc_ff, acc_in;
   logic [OFFSET_W-1:0]   work_ff, work_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ACTION_W-1:0]   act_ff, act_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [BYTES_W-1:0]    size_eff;
   logic [COUNT_W-1:0]    count_eff;
   logic                  list_empty;
   logic                  csr_wr;

   logic [OFFSET_W-1:0]   alu_a, alu_b;
   logic                  alu_sub;
   logic [OFFSET_W:0]     alu_sum;
   logic [BYTES_W:0]      rem_shift;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [IDX_W-1:0]      ram_wr_data;
   logic [IDX_W-1:0]      ram_rd_data;

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Configuration registers
   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SEL_COUNT) ? CSR_DATA_W'(block_count_ff)
                                               : CSR_DATA_W'(block_bytes_ff);

   always_comb begin
      block_bytes_in = block_bytes_ff;
      block_count_in = block_count_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_SEL_BYTES: block_bytes_in = pwdata[BYTES_W-1:0];
            CSR_SEL_COUNT: block_count_in = pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (block_bytes_ff < LINK_BYTES) begin
         size_eff = LINK_BYTES;
      end else if (block_bytes_ff > BYTES_W'(SZ_CAP)) begin
         size_eff = BYTES_W'(SZ_CAP);
      end else begin
         size_eff = block_bytes_ff;
      end
      count_eff = (block_count_ff > COUNT_W'(CNT_CAP)) ? COUNT_W'(CNT_CAP) : block_count_ff;
   end

   assign list_empty = head_ff >= IDX_W'(MAX_BLOCKS);

   // Shared add/subtract unit
   assign rem_shift = {acc_ff[BYTES_W-1:0], work_ff[OFFSET_W-1]};

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      if (state_ff == ST_MUL) begin
         alu_a = {acc_ff[OFFSET_W-2:0], 1'b0};
         alu_b = work_ff[OFFSET_W-1] ? OFFSET_W'(head_ff) : '0;
      end else if (state_ff == ST_DIV) begin
         alu_a   = OFFSET_W'(rem_shift);
         alu_b   = OFFSET_W'(size_eff);
         alu_sub = 1'b1;
      end
      alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (OFFSET_W + 1)'(alu_sub);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      prev_in      = prev_ff;
      sweep_in     = sweep_ff;
      acc_in       = acc_ff;
      work_in      = work_ff;
      step_in      = step_ff;
      act_in       = act_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sweep_ff;
      ram_wr_data  = prev_ff;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               act_in    = req_word.action;
               acc_in    = '0;
               status_in = STS_OK;
               unique case (req_word.action)
                  ACT_ALLOC: begin
                     if (list_empty) begin
                        status_in = STS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        work_in  = {size_eff, (OFFSET_W - BYTES_W)'(0)};
                        step_in  = STEP_W'(BYTES_W - 1);
                        state_in = ST_MUL;
                     end
                  end
                  ACT_FREE: begin
                     work_in  = req_word.free_offset;
                     step_in  = STEP_W'(OFFSET_W - 1);
                     state_in = ST_DIV;
                  end
                  ACT_REBUILD: begin
                     sweep_in = '0;
                     prev_in  = IDX_W'(MAX_BLOCKS);
                     if (count_eff == '0) begin
                        head_in  = IDX_W'(MAX_BLOCKS);
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SWEEP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_MUL: begin
            acc_in  = alu_sum[OFFSET_W-1:0];
            work_in = {work_ff[OFFSET_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               head_in  = ram_rd_data;
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            acc_in  = alu_sum[OFFSET_W] ? alu_sum[OFFSET_W-1:0] : OFFSET_W'(rem_shift);
            work_in = {work_ff[OFFSET_W-2:0], alu_sum[OFFSET_W]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // work holds the quotient, acc the remainder
            if (work_ff >= OFFSET_W'(count_eff)) begin
               status_in = STS_RANGE;
            end else if (acc_ff != '0) begin
               status_in = STS_ALIGN;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = work_ff[AW-1:0];
               ram_wr_data = head_ff;
               head_in     = IDX_W'(work_ff[AW-1:0]);
            end
            acc_in   = '0;
            state_in = ST_RESP;
         end
         ST_SWEEP: begin
            ram_wr_en = 1'b1;
            prev_in   = IDX_W'(sweep_ff);
            sweep_in  = sweep_ff + AW'(1);
            if (CW'(sweep_ff) + CW'(1) == CW'(count_eff)) begin
               head_in  = IDX_W'(sweep_ff);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.status       = status_ff;
               rsp_word_in.alloc_offset = (act_ff == ACT_ALLOC) ? acc_ff : '0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_bytes_ff <= RST_BLOCK_BYTES;
         block_count_ff <= RST_BLOCK_COUNT;
         head_ff        <= IDX_W'(MAX_BLOCKS);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_bytes_ff <= block_bytes_in;
         block_count_ff <= block_count_in;
         head_ff        <= head_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      sweep_ff    <= sweep_in;
      acc_ff      <= acc_in;
      work_ff     <= work_in;
      step_ff     <= step_in;
      act_ff      <= act_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(MAX_BLOCKS))
      else $error("free list head beyond sentinel");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted word not taken into work");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result word loaded outside response state");

   a_err_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != STS_OK |-> rsp_word_ff.alloc_offset == '0)
      else $error("nonzero offset on failed request");

endmodule
